[design/eccr_pkg.sv]
// ============================================================================
// eccr_pkg: shared types and constants of the elastic circle collision core
// Holds the per-stage word record, the stage map of the pipeline and the
// rounding and saturation helpers used by the datapath.
// ============================================================================
package eccr_pkg;

    // Iteration counts of the pipelined square root and the two dividers.
    localparam int SQRT_STEPS = 25;
    localparam int NDIV_STEPS = 17;
    localparam int JDIV_STEPS = 44;

    // Stage map of the pipeline, in order of travel.
    localparam int ST_DIFF  = 0;
    localparam int ST_SQR   = 1;
    localparam int ST_CMP   = 2;
    localparam int ST_SQRT0 = 3;
    localparam int ST_NPREP = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_NDIV0 = ST_NPREP + 1;
    localparam int ST_NFIN  = ST_NDIV0 + NDIV_STEPS;
    localparam int ST_MUL1  = ST_NFIN + 1;
    localparam int ST_SUM1  = ST_MUL1 + 1;
    localparam int ST_JPREP = ST_SUM1 + 1;
    localparam int ST_JDIV0 = ST_JPREP + 1;
    localparam int ST_JFIN  = ST_JDIV0 + JDIV_STEPS;
    localparam int ST_MUL2  = ST_JFIN + 1;
    localparam int ST_OUT   = ST_MUL2 + 1;
    localparam int DEPTH    = ST_OUT + 1;

    // Widths of the stream words.
    localparam int IN_W  = 264;
    localparam int OUT_W = 200;

    // Everything one pair carries down the pipeline.
    typedef struct packed {
        logic signed [23:0] x1;
        logic signed [23:0] y1;
        logic signed [23:0] vx1;
        logic signed [23:0] vy1;
        logic signed [23:0] x2;
        logic signed [23:0] y2;
        logic signed [23:0] vx2;
        logic signed [23:0] vy2;
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [20:0]        rs;
        logic [48:0]        dxsq;
        logic [48:0]        dysq;
        logic [41:0]        rsq;
        logic [49:0]        dsq;
        logic               hit;
        logic [25:0]        sq_rem;
        logic [24:0]        sq_root;
        logic [24:0]        d;
        logic               dzero;
        logic signed [22:0] overlap;
        logic [41:0]        nx_num;
        logic [41:0]        ny_num;
        logic               nx_neg;
        logic               ny_neg;
        logic [24:0]        nx_rem;
        logic [24:0]        ny_rem;
        logic [16:0]        nx_q;
        logic [16:0]        ny_q;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [40:0] cpx;
        logic signed [40:0] cpy;
        logic signed [42:0] dpx;
        logic signed [42:0] dpy;
        logic signed [25:0] px1;
        logic signed [25:0] py1;
        logic signed [25:0] px2;
        logic signed [25:0] py2;
        logic signed [43:0] dn;
        logic [16:0]        msum;
        logic               j_neg;
        logic [59:0]        j1_num;
        logic [59:0]        j2_num;
        logic [16:0]        j1_rem;
        logic [16:0]        j2_rem;
        logic [43:0]        j1_q;
        logic [43:0]        j2_q;
        logic signed [44:0] j1;
        logic signed [44:0] j2;
        logic               mok;
        logic signed [62:0] a1x;
        logic signed [62:0] a1y;
        logic signed [62:0] a2x;
        logic signed [62:0] a2y;
        logic               collided;
        logic [23:0]        o_x1;
        logic [23:0]        o_y1;
        logic [23:0]        o_vx1;
        logic [23:0]        o_vy1;
        logic [23:0]        o_x2;
        logic [23:0]        o_y2;
        logic [23:0]        o_vx2;
        logic [23:0]        o_vy2;
    } pair_t;

    // Clamp a wide signed value to the 24 bit signed range.
    function automatic logic [23:0] sat24(input logic signed [32:0] v);
        logic [23:0] r;
        if (v > 33'sd8388607)
            r = 24'h7FFFFF;
        else if (v < -33'sd8388608)
            r = 24'h800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // Divide by 2^32 rounding to nearest, ties away from zero.
    function automatic logic signed [31:0] rnd_q32(input logic signed [62:0] a);
        logic [62:0]        mag;
        logic [30:0]        q;
        logic signed [31:0] r;
        mag = a[62] ? 63'(-a) : a;
        q   = 31'((mag + 63'(64'd1 << 31)) >> 32);
        r   = {1'b0, q};
        if (a[62])
            r = -r;
        return r;
    endfunction

endpackage

[design/elastic_circle_collision_resolve_core.sv]
// ============================================================================
// elastic_circle_collision_resolve_core: two ball elastic collision resolver
// Tests a pair of circles for overlap, pushes them apart along the normal and
// applies the one dimensional elastic formula to the normal velocities.
// ============================================================================
// Usage:
//   The slave stream takes one ball pair per word and the master stream gives
//   one result word per pair, in the same order. Words are accepted whenever
//   tvalid and tready are high together on a rising edge of clk.
//   The datapath is a 97 stage pipeline: an integer square root resolving one
//   root bit per stage, a 17 stage divider for the unit normal and a 44 stage
//   divider for the mass weighted impulse, plus multiply and round stages.
//   Throughput is one pair per cycle, set by the pipeline, which takes a new
//   word every cycle that the output is free or being taken.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits, so the block comes up empty and ready.
//   A pair that does not overlap passes through with collided low.
// ============================================================================
module elastic_circle_collision_resolve_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // first_x, first_y, first_vx, first_vy, first_mass, first_radius,
    // second_x, second_y, second_vx, second_vy, second_mass, second_radius
    input  logic [eccr_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // collided, new_first_x, new_first_y, new_first_vx, new_first_vy,
    // new_second_x, new_second_y, new_second_vx, new_second_vy, zero pad
    output logic [eccr_pkg::OUT_W-1:0]  m_axis_tdata
);

    eccr_pkg::pair_t              pipe [eccr_pkg::DEPTH];
    logic [eccr_pkg::DEPTH-1:0]   vld_vec;
    logic                         adv;

    // The whole pipeline moves when the output stage is empty or taken.
    assign adv           = !vld_vec[eccr_pkg::DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;

    for (genvar k = 0; k < eccr_pkg::DEPTH; k++) begin : g_stage
        localparam int P = (k == 0) ? 0 : k - 1;
        eccr_pkg::pair_t stg_next;
        eccr_pkg::pair_t stg_reg;
        logic            vld_reg;

        if (k == eccr_pkg::ST_DIFF) begin : g_diff
            // Unpack the word, form the center deltas and the radius sum.
            always_comb
            begin
                stg_next     = '0;
                stg_next.x1  = s_axis_tdata[23:0];
                stg_next.y1  = s_axis_tdata[47:24];
                stg_next.vx1 = s_axis_tdata[71:48];
                stg_next.vy1 = s_axis_tdata[95:72];
                stg_next.m1  = s_axis_tdata[111:96];
                stg_next.x2  = s_axis_tdata[155:132];
                stg_next.y2  = s_axis_tdata[179:156];
                stg_next.vx2 = s_axis_tdata[203:180];
                stg_next.vy2 = s_axis_tdata[227:204];
                stg_next.m2  = s_axis_tdata[243:228];
                stg_next.dx  = {s_axis_tdata[23], s_axis_tdata[23:0]}
                             - {s_axis_tdata[155], s_axis_tdata[155:132]};
                stg_next.dy  = {s_axis_tdata[47], s_axis_tdata[47:24]}
                             - {s_axis_tdata[179], s_axis_tdata[179:156]};
                stg_next.rs  = 21'(s_axis_tdata[131:112]) + 21'(s_axis_tdata[263:244]);
            end
        end
        else if (k == eccr_pkg::ST_SQR) begin : g_sqr
            // Square the deltas and the radius sum.
            always_comb
            begin
                stg_next      = pipe[P];
                stg_next.dxsq = 49'(pipe[P].dx * pipe[P].dx);
                stg_next.dysq = 49'(pipe[P].dy * pipe[P].dy);
                stg_next.rsq  = 42'(pipe[P].rs * pipe[P].rs);
            end
        end
        else if (k == eccr_pkg::ST_CMP) begin : g_cmp
            // Squared distance and the overlap test.
            always_comb
            begin : c_cmp
                logic [49:0] dsq;
                dsq              = 50'(pipe[P].dxsq) + 50'(pipe[P].dysq);
                stg_next         = pipe[P];
                stg_next.dsq     = dsq;
                stg_next.hit     = (dsq <= 50'(pipe[P].rsq));
                stg_next.sq_rem  = '0;
                stg_next.sq_root = '0;
            end
        end
        else if (k >= eccr_pkg::ST_SQRT0 && k < eccr_pkg::ST_NPREP) begin : g_sqrt
            localparam int I = k - eccr_pkg::ST_SQRT0;
            // One root bit per stage, two radicand bits brought down.
            always_comb
            begin : c_sqrt
                logic [27:0] rem2;
                logic [27:0] trial;
                rem2     = {pipe[P].sq_rem, pipe[P].dsq[49-2*I -: 2]};
                trial    = {1'b0, pipe[P].sq_root, 2'b01};
                stg_next = pipe[P];
                if (rem2 >= trial)
                begin
                    stg_next.sq_rem  = 26'(rem2 - trial);
                    stg_next.sq_root = {pipe[P].sq_root[23:0], 1'b1};
                end
                else
                begin
                    stg_next.sq_rem  = rem2[25:0];
                    stg_next.sq_root = {pipe[P].sq_root[23:0], 1'b0};
                end
            end
        end
        else if (k == eccr_pkg::ST_NPREP) begin : g_nprep
            // Overlap and the rounded dividends of the unit normal.
            always_comb
            begin : c_nprep
                logic [24:0] dxmag;
                logic [24:0] dymag;
                logic [41:0] nxn;
                logic [41:0] nyn;
                dxmag = pipe[P].dx[24] ? 25'(-pipe[P].dx) : pipe[P].dx;
                dymag = pipe[P].dy[24] ? 25'(-pipe[P].dy) : pipe[P].dy;
                nxn   = 42'({dxmag, 16'b0}) + 42'(pipe[P].sq_root >> 1);
                nyn   = 42'({dymag, 16'b0}) + 42'(pipe[P].sq_root >> 1);
                stg_next         = pipe[P];
                stg_next.d       = pipe[P].sq_root;
                stg_next.dzero   = (pipe[P].sq_root == '0);
                stg_next.overlap = 23'(25'(pipe[P].rs) - pipe[P].sq_root);
                stg_next.nx_neg  = pipe[P].dx[24];
                stg_next.ny_neg  = pipe[P].dy[24];
                stg_next.nx_num  = nxn;
                stg_next.ny_num  = nyn;
                stg_next.nx_rem  = nxn[41:17];
                stg_next.ny_rem  = nyn[41:17];
                stg_next.nx_q    = '0;
                stg_next.ny_q    = '0;
            end
        end
        else if (k >= eccr_pkg::ST_NDIV0 && k < eccr_pkg::ST_NFIN) begin : g_ndiv
            localparam int I = k - eccr_pkg::ST_NDIV0;
            // One quotient bit of each normal component per stage.
            always_comb
            begin : c_ndiv
                logic [25:0] rx;
                logic [25:0] ry;
                rx       = {pipe[P].nx_rem, pipe[P].nx_num[16-I]};
                ry       = {pipe[P].ny_rem, pipe[P].ny_num[16-I]};
                stg_next = pipe[P];
                if (rx >= {1'b0, pipe[P].d})
                begin
                    stg_next.nx_rem = 25'(rx - {1'b0, pipe[P].d});
                    stg_next.nx_q   = {pipe[P].nx_q[15:0], 1'b1};
                end
                else
                begin
                    stg_next.nx_rem = rx[24:0];
                    stg_next.nx_q   = {pipe[P].nx_q[15:0], 1'b0};
                end
                if (ry >= {1'b0, pipe[P].d})
                begin
                    stg_next.ny_rem = 25'(ry - {1'b0, pipe[P].d});
                    stg_next.ny_q   = {pipe[P].ny_q[15:0], 1'b1};
                end
                else
                begin
                    stg_next.ny_rem = ry[24:0];
                    stg_next.ny_q   = {pipe[P].ny_q[15:0], 1'b0};
                end
            end
        end
        else if (k == eccr_pkg::ST_NFIN) begin : g_nfin
            // Apply signs; coincident centers take the normal (1,0).
            always_comb
            begin : c_nfin
                logic signed [17:0] qx;
                logic signed [17:0] qy;
                qx       = {1'b0, pipe[P].nx_q};
                qy       = {1'b0, pipe[P].ny_q};
                stg_next = pipe[P];
                if (pipe[P].dzero)
                begin
                    stg_next.nx = 18'sd65536;
                    stg_next.ny = '0;
                end
                else
                begin
                    stg_next.nx = pipe[P].nx_neg ? -qx : qx;
                    stg_next.ny = pipe[P].ny_neg ? -qy : qy;
                end
            end
        end
        else if (k == eccr_pkg::ST_MUL1) begin : g_mul1
            // Correction products and the normal velocity terms.
            always_comb
            begin : c_mul1
                logic signed [24:0] dvx;
                logic signed [24:0] dvy;
                dvx          = 25'(pipe[P].vx2) - 25'(pipe[P].vx1);
                dvy          = 25'(pipe[P].vy2) - 25'(pipe[P].vy1);
                stg_next     = pipe[P];
                stg_next.cpx = 41'(pipe[P].nx * pipe[P].overlap);
                stg_next.cpy = 41'(pipe[P].ny * pipe[P].overlap);
                stg_next.dpx = 43'(dvx * pipe[P].nx);
                stg_next.dpy = 43'(dvy * pipe[P].ny);
            end
        end
        else if (k == eccr_pkg::ST_SUM1) begin : g_sum1
            // Round the half overlap push and correct both positions.
            always_comb
            begin : c_sum1
                logic [40:0]        mx;
                logic [40:0]        my;
                logic signed [25:0] cx;
                logic signed [25:0] cy;
                mx = pipe[P].cpx[40] ? 41'(-pipe[P].cpx) : pipe[P].cpx;
                my = pipe[P].cpy[40] ? 41'(-pipe[P].cpy) : pipe[P].cpy;
                cx = {2'b0, 24'((mx + 41'(42'd1 << 16)) >> 17)};
                cy = {2'b0, 24'((my + 41'(42'd1 << 16)) >> 17)};
                if (pipe[P].cpx[40])
                    cx = -cx;
                if (pipe[P].cpy[40])
                    cy = -cy;
                stg_next     = pipe[P];
                stg_next.px1 = 26'(pipe[P].x1) + cx;
                stg_next.py1 = 26'(pipe[P].y1) + cy;
                stg_next.px2 = 26'(pipe[P].x2) - cx;
                stg_next.py2 = 26'(pipe[P].y2) - cy;
                stg_next.dn  = 44'(pipe[P].dpx) + 44'(pipe[P].dpy);
            end
        end
        else if (k == eccr_pkg::ST_JPREP) begin : g_jprep
            // Mass weighted impulse dividends, rounding offset included.
            always_comb
            begin : c_jprep
                logic [42:0] dnmag;
                logic [16:0] ms;
                logic [59:0] n1;
                logic [59:0] n2;
                dnmag = pipe[P].dn[43] ? 43'(-pipe[P].dn) : pipe[P].dn[42:0];
                ms    = 17'(pipe[P].m1) + 17'(pipe[P].m2);
                n1    = 60'({pipe[P].m2, 1'b0}) * 60'(dnmag) + 60'(ms >> 1);
                n2    = 60'({pipe[P].m1, 1'b0}) * 60'(dnmag) + 60'(ms >> 1);
                stg_next        = pipe[P];
                stg_next.msum   = ms;
                stg_next.j_neg  = pipe[P].dn[43];
                stg_next.j1_num = n1;
                stg_next.j2_num = n2;
                stg_next.j1_rem = {1'b0, n1[59:44]};
                stg_next.j2_rem = {1'b0, n2[59:44]};
                stg_next.j1_q   = '0;
                stg_next.j2_q   = '0;
            end
        end
        else if (k >= eccr_pkg::ST_JDIV0 && k < eccr_pkg::ST_JFIN) begin : g_jdiv
            localparam int I = k - eccr_pkg::ST_JDIV0;
            // One quotient bit of each impulse per stage.
            always_comb
            begin : c_jdiv
                logic [17:0] r1;
                logic [17:0] r2;
                r1       = {pipe[P].j1_rem, pipe[P].j1_num[43-I]};
                r2       = {pipe[P].j2_rem, pipe[P].j2_num[43-I]};
                stg_next = pipe[P];
                if (r1 >= {1'b0, pipe[P].msum})
                begin
                    stg_next.j1_rem = 17'(r1 - {1'b0, pipe[P].msum});
                    stg_next.j1_q   = {pipe[P].j1_q[42:0], 1'b1};
                end
                else
                begin
                    stg_next.j1_rem = r1[16:0];
                    stg_next.j1_q   = {pipe[P].j1_q[42:0], 1'b0};
                end
                if (r2 >= {1'b0, pipe[P].msum})
                begin
                    stg_next.j2_rem = 17'(r2 - {1'b0, pipe[P].msum});
                    stg_next.j2_q   = {pipe[P].j2_q[42:0], 1'b1};
                end
                else
                begin
                    stg_next.j2_rem = r2[16:0];
                    stg_next.j2_q   = {pipe[P].j2_q[42:0], 1'b0};
                end
            end
        end
        else if (k == eccr_pkg::ST_JFIN) begin : g_jfin
            // Signed impulses; the second ball takes the opposite sign.
            always_comb
            begin : c_jfin
                logic signed [44:0] q1;
                logic signed [44:0] q2;
                q1           = {1'b0, pipe[P].j1_q};
                q2           = {1'b0, pipe[P].j2_q};
                stg_next     = pipe[P];
                stg_next.j1  = pipe[P].j_neg ? -q1 : q1;
                stg_next.j2  = pipe[P].j_neg ? q2 : -q2;
                stg_next.mok = (pipe[P].msum != '0);
            end
        end
        else if (k == eccr_pkg::ST_MUL2) begin : g_mul2
            // Project the impulses back onto the axes.
            always_comb
            begin
                stg_next     = pipe[P];
                stg_next.a1x = 63'(pipe[P].j1 * pipe[P].nx);
                stg_next.a1y = 63'(pipe[P].j1 * pipe[P].ny);
                stg_next.a2x = 63'(pipe[P].j2 * pipe[P].nx);
                stg_next.a2y = 63'(pipe[P].j2 * pipe[P].ny);
            end
        end
        else begin : g_out
            // Round the velocity changes, saturate and pick the result.
            always_comb
            begin : c_out
                logic signed [32:0] nvx1;
                logic signed [32:0] nvy1;
                logic signed [32:0] nvx2;
                logic signed [32:0] nvy2;
                nvx1 = 33'(pipe[P].vx1);
                nvy1 = 33'(pipe[P].vy1);
                nvx2 = 33'(pipe[P].vx2);
                nvy2 = 33'(pipe[P].vy2);
                if (pipe[P].mok)
                begin
                    nvx1 = nvx1 + 33'(eccr_pkg::rnd_q32(pipe[P].a1x));
                    nvy1 = nvy1 + 33'(eccr_pkg::rnd_q32(pipe[P].a1y));
                    nvx2 = nvx2 + 33'(eccr_pkg::rnd_q32(pipe[P].a2x));
                    nvy2 = nvy2 + 33'(eccr_pkg::rnd_q32(pipe[P].a2y));
                end
                stg_next          = pipe[P];
                stg_next.collided = pipe[P].hit;
                if (pipe[P].hit)
                begin
                    stg_next.o_x1  = eccr_pkg::sat24(33'(pipe[P].px1));
                    stg_next.o_y1  = eccr_pkg::sat24(33'(pipe[P].py1));
                    stg_next.o_x2  = eccr_pkg::sat24(33'(pipe[P].px2));
                    stg_next.o_y2  = eccr_pkg::sat24(33'(pipe[P].py2));
                    stg_next.o_vx1 = eccr_pkg::sat24(nvx1);
                    stg_next.o_vy1 = eccr_pkg::sat24(nvy1);
                    stg_next.o_vx2 = eccr_pkg::sat24(nvx2);
                    stg_next.o_vy2 = eccr_pkg::sat24(nvy2);
                end
                else
                begin
                    stg_next.o_x1  = pipe[P].x1;
                    stg_next.o_y1  = pipe[P].y1;
                    stg_next.o_x2  = pipe[P].x2;
                    stg_next.o_y2  = pipe[P].y2;
                    stg_next.o_vx1 = pipe[P].vx1;
                    stg_next.o_vy1 = pipe[P].vy1;
                    stg_next.o_vx2 = pipe[P].vx2;
                    stg_next.o_vy2 = pipe[P].vy2;
                end
            end
        end

        // Stage valid bit, cleared by reset.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= (k == 0) ? s_axis_tvalid : vld_vec[P];
        end

        // Stage payload, no reset needed.
        always_ff @(posedge clk)
        begin
            if (adv)
                stg_reg <= stg_next;
        end

        assign pipe[k]    = stg_reg;
        assign vld_vec[k] = vld_reg;
    end

    // Master side is the last stage.
    assign m_axis_tvalid = vld_vec[eccr_pkg::DEPTH-1];
    assign m_axis_tdata  = {7'b0,
                            pipe[eccr_pkg::ST_OUT].o_vy2,
                            pipe[eccr_pkg::ST_OUT].o_vx2,
                            pipe[eccr_pkg::ST_OUT].o_y2,
                            pipe[eccr_pkg::ST_OUT].o_x2,
                            pipe[eccr_pkg::ST_OUT].o_vy1,
                            pipe[eccr_pkg::ST_OUT].o_vx1,
                            pipe[eccr_pkg::ST_OUT].o_y1,
                            pipe[eccr_pkg::ST_OUT].o_x1,
                            pipe[eccr_pkg::ST_OUT].collided};

    // A stall freezes the occupancy of every stage.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_vec))
        else $error("pipeline occupancy changed during a stall");

    // The square root remainder stays within twice the root.
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_vec[eccr_pkg::ST_NPREP-1] |->
            ({1'b0, pipe[eccr_pkg::ST_NPREP-1].sq_rem}
             <= {pipe[eccr_pkg::ST_NPREP-1].sq_root, 1'b0}))
        else $error("square root remainder out of range");

    // A colliding pair never has a negative overlap.
    a_overlap_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_vec[eccr_pkg::ST_NPREP] && pipe[eccr_pkg::ST_NPREP].hit) |->
            !pipe[eccr_pkg::ST_NPREP].overlap[22])
        else $error("negative overlap on a collision");

    // A pair that misses leaves the block unchanged; x1, vx1 and vy2 are checked.
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !pipe[eccr_pkg::ST_OUT].collided) |->
            (pipe[eccr_pkg::ST_OUT].o_x1 == pipe[eccr_pkg::ST_OUT].x1 &&
             pipe[eccr_pkg::ST_OUT].o_vy2 == pipe[eccr_pkg::ST_OUT].vy2 &&
             pipe[eccr_pkg::ST_OUT].o_vx1 == pipe[eccr_pkg::ST_OUT].vx1))
        else $error("non-colliding pair was modified");

endmodule
